FILE: rtl/hmf_pkg.sv
// ----------------------------------------------------------------------------
// hmf_pkg
// Shared constants for the HTTP/1.1 message framer: phases, byte kinds,
// error codes and the matched header and coding names.
// ----------------------------------------------------------------------------
package hmf_pkg;

    localparam int LENGTH_BITS_DEF = 32;

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_HEAD  = 3'd1;
    localparam logic [2:0] PH_BODY  = 3'd2;
    localparam logic [2:0] PH_CSIZE = 3'd3;
    localparam logic [2:0] PH_CDATA = 3'd4;
    localparam logic [2:0] PH_CTERM = 3'd5;
    localparam logic [2:0] PH_TRAIL = 3'd6;
    localparam logic [2:0] PH_DONE  = 3'd7;

    localparam logic [2:0] KIND_START  = 3'd0;
    localparam logic [2:0] KIND_HEADER = 3'd1;
    localparam logic [2:0] KIND_BODY   = 3'd2;
    localparam logic [2:0] KIND_CSIZE  = 3'd3;
    localparam logic [2:0] KIND_CTERM  = 3'd4;
    localparam logic [2:0] KIND_TRAIL  = 3'd5;
    localparam logic [2:0] KIND_LF     = 3'd6;
    localparam logic [2:0] KIND_NONE   = 3'd7;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_COLON = 3'd1;
    localparam logic [2:0] ERR_ENCODING = 3'd2;
    localparam logic [2:0] ERR_LENGTH   = 3'd3;
    localparam logic [2:0] ERR_CSIZE    = 3'd4;
    localparam logic [2:0] ERR_NO_CRLF  = 3'd5;
    localparam logic [2:0] ERR_OVERFLOW = 3'd6;

    localparam logic [1:0] VS_NAME  = 2'd0;
    localparam logic [1:0] VS_SKIP  = 2'd1;
    localparam logic [1:0] VS_VALUE = 2'd2;
    localparam logic [1:0] VS_OVF   = 2'd3;

    localparam logic [1:0] LS_OK   = 2'd0;
    localparam logic [1:0] LS_BAD  = 2'd1;
    localparam logic [1:0] LS_OVF  = 2'd2;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int CL_LEN = 14;
    localparam int TE_LEN = 17;
    localparam int CK_LEN = 7;

    localparam logic [8*CL_LEN-1:0] CL_TEXT = "Content-Length";
    localparam logic [8*TE_LEN-1:0] TE_TEXT = "Transfer-Encoding";
    localparam logic [8*CK_LEN-1:0] CK_TEXT = "chunked";

    function automatic logic [7:0] cl_byte(input logic [4:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (int'(idx) < CL_LEN) begin
            b = CL_TEXT[8*(CL_LEN-1-int'(idx)) +: 8];
        end
        return b;
    endfunction

    function automatic logic [7:0] te_byte(input logic [4:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (int'(idx) < TE_LEN) begin
            b = TE_TEXT[8*(TE_LEN-1-int'(idx)) +: 8];
        end
        return b;
    endfunction

    function automatic logic [7:0] ck_byte(input logic [2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (int'(idx) < CK_LEN) begin
            b = CK_TEXT[8*(CK_LEN-1-int'(idx)) +: 8];
        end
        return b;
    endfunction

endpackage

FILE: rtl/http_message_framer_chunked.sv
// Output: a byte accepted at a clock edge has its result on the outputs
// from the next cycle on (one register stage).
// Throughput: one byte per cycle while o_ready is high; a byte's parse
// state update is one pass of logic, widest step the times-ten accumulate.
// Reset: synchronous, active low; clears the parse state and the result valid
// flag, leaving the framer at the start line of a new message.
// ----------------------------------------------------------------------------
// http_message_framer_chunked
// Byte-serial HTTP/1.1 message framer: classifies each byte, tracks
// Content-Length and chunked framing, flags completion and sticky errors.
// ----------------------------------------------------------------------------
module http_message_framer_chunked
    import hmf_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_new_message,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte_out,
    output logic [2:0] o_byte_kind,
    output logic       o_message_done,
    output logic [2:0] o_error_code
);

    localparam int LB = LENGTH_BITS;

    typedef struct packed {
        logic [2:0]    phase;
        logic          cr_pending;
        logic          line_nonempty;
        logic [4:0]    name_pos;
        logic [1:0]    name_cand;
        logic [1:0]    value_stage;
        logic          value_ok;
        logic [LB-1:0] acc;
        logic [2:0]    enc_pos;
        logic          len_seen;
        logic [LB-1:0] decl_len;
        logic [1:0]    len_status;
        logic          enc_seen;
        logic          enc_chunked;
        logic [LB-1:0] body_rem;
        logic [2:0]    err;
    } t_parse;

    typedef struct packed {
        t_parse     st;
        logic [2:0] kind;
        logic       done;
    } t_res;

    function automatic t_parse line_restart(input t_parse s_in);
        t_parse s;
        s = s_in;
        s.line_nonempty = 1'b0;
        s.name_pos      = '0;
        s.name_cand     = 2'b11;
        s.value_stage   = VS_NAME;
        s.value_ok      = 1'b1;
        s.acc           = '0;
        s.enc_pos       = '0;
        return s;
    endfunction

    function automatic t_parse parse_reset();
        t_parse s;
        s             = '0;
        s             = line_restart(s);
        s.phase       = PH_START;
        s.err         = ERR_NONE;
        s.len_status  = LS_OK;
        return s;
    endfunction

    function automatic t_parse header_char(input t_parse s_in, input logic [7:0] c);
        t_parse          s;
        logic [1:0]      keep;
        logic [3:0]      d;
        logic [LB+3:0]   prod;
        s    = s_in;
        keep = 2'b00;
        d    = c[3:0];
        prod = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1) + {{LB{1'b0}}, d};
        if (s.value_stage == VS_NAME) begin
            if (c == CH_COLON) begin
                keep[0] = s.name_cand[0] && (int'(s.name_pos) == CL_LEN);
                keep[1] = s.name_cand[1] && (int'(s.name_pos) == TE_LEN);
                s.name_cand   = keep;
                s.value_stage = VS_SKIP;
            end else begin
                if (int'(s.name_pos) >= CL_LEN || cl_byte(s.name_pos) != c) begin
                    s.name_cand[0] = 1'b0;
                end
                if (int'(s.name_pos) >= TE_LEN || te_byte(s.name_pos) != c) begin
                    s.name_cand[1] = 1'b0;
                end
                if (s.name_pos != 5'd31) begin
                    s.name_pos = s.name_pos + 5'd1;
                end
            end
        end else if (!(s.value_stage == VS_SKIP && c == CH_SPACE)) begin
            if (s.value_stage == VS_SKIP) begin
                s.value_stage = VS_VALUE;
            end
            if (s.name_cand[0]) begin
                if (s.value_ok && s.value_stage != VS_OVF) begin
                    if (c inside {[8'h30:8'h39]}) begin
                        if (prod[LB+3:LB] != 4'd0) begin
                            s.value_stage = VS_OVF;
                        end else begin
                            s.acc = prod[LB-1:0];
                        end
                    end else begin
                        s.value_ok = 1'b0;
                    end
                end
            end else if (s.name_cand[1]) begin
                if (s.value_ok && int'(s.enc_pos) < CK_LEN && c == ck_byte(s.enc_pos)) begin
                    s.enc_pos = s.enc_pos + 3'd1;
                end else begin
                    s.value_ok = 1'b0;
                end
            end
        end
        return s;
    endfunction

    function automatic t_parse hex_char(input t_parse s_in, input logic [7:0] c);
        t_parse     s;
        logic [3:0] d;
        logic       is_hex;
        s      = s_in;
        d      = 4'd0;
        is_hex = 1'b1;
        if (c inside {[8'h30:8'h39]}) begin
            d = c[3:0];
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            d = c[3:0] + 4'd9;
        end else begin
            is_hex = 1'b0;
        end
        if (s.value_ok && s.value_stage != VS_OVF) begin
            if (!is_hex) begin
                s.value_ok = 1'b0;
            end else if (s.acc[LB-1:LB-4] != 4'd0) begin
                s.value_stage = VS_OVF;
            end else begin
                s.acc = {s.acc[LB-5:0], d};
            end
        end
        return s;
    endfunction

    function automatic t_parse line_char(input t_parse s_in, input logic [7:0] c);
        t_parse s;
        s = s_in;
        s.line_nonempty = 1'b1;
        if (s.phase == PH_HEAD || s.phase == PH_TRAIL) begin
            s = header_char(s, c);
        end else if (s.phase == PH_CSIZE) begin
            s = hex_char(s, c);
        end
        return s;
    endfunction

    function automatic t_res headers_end(input t_parse s_in);
        t_res r;
        r      = '0;
        r.st   = s_in;
        r.done = 1'b0;
        if (r.st.enc_seen) begin
            if (r.st.enc_chunked) begin
                r.st.body_rem = '0;
                r.st.phase    = PH_CSIZE;
            end else begin
                r.st.err = ERR_ENCODING;
            end
        end else if (r.st.len_seen && r.st.len_status == LS_OVF) begin
            r.st.err = ERR_OVERFLOW;
        end else if (r.st.len_seen && r.st.len_status == LS_BAD) begin
            r.st.err = ERR_LENGTH;
        end else if (r.st.len_seen && r.st.decl_len != '0) begin
            r.st.body_rem = r.st.decl_len;
            r.st.phase    = PH_BODY;
        end else begin
            if (r.st.len_seen) begin
                r.st.body_rem = r.st.decl_len;
            end
            r.st.phase = PH_DONE;
            r.done     = 1'b1;
        end
        return r;
    endfunction

    function automatic t_res line_end(input t_parse s_in);
        t_res r;
        r      = '0;
        r.st   = s_in;
        r.done = 1'b0;
        case (r.st.phase)
            PH_START: begin
                r.st.phase = PH_HEAD;
            end
            PH_HEAD: begin
                if (!r.st.line_nonempty) begin
                    r = headers_end(r.st);
                end else if (r.st.value_stage == VS_NAME) begin
                    r.st.err = ERR_NO_COLON;
                end else begin
                    if (r.st.name_cand[0] && !r.st.len_seen) begin
                        r.st.len_seen = 1'b1;
                        r.st.decl_len = r.st.acc;
                        if (r.st.value_stage == VS_OVF) begin
                            r.st.len_status = LS_OVF;
                        end else if (!r.st.value_ok || r.st.value_stage == VS_SKIP) begin
                            r.st.len_status = LS_BAD;
                        end else begin
                            r.st.len_status = LS_OK;
                        end
                    end
                    if (r.st.name_cand[1] && !r.st.enc_seen) begin
                        r.st.enc_seen    = 1'b1;
                        r.st.enc_chunked = r.st.value_ok && r.st.value_stage == VS_VALUE
                                           && int'(r.st.enc_pos) == CK_LEN;
                    end
                end
            end
            PH_CSIZE: begin
                if (r.st.value_stage == VS_OVF) begin
                    r.st.err = ERR_OVERFLOW;
                end else if (!r.st.line_nonempty || !r.st.value_ok) begin
                    r.st.err = ERR_CSIZE;
                end else if (r.st.acc == '0) begin
                    r.st.phase = PH_TRAIL;
                end else begin
                    r.st.body_rem = r.st.acc;
                    r.st.phase    = PH_CDATA;
                end
            end
            PH_CTERM: begin
                if (r.st.line_nonempty) begin
                    r.st.err = ERR_NO_CRLF;
                end else begin
                    r.st.phase = PH_CSIZE;
                end
            end
            PH_TRAIL: begin
                if (!r.st.line_nonempty) begin
                    r.st.phase = PH_DONE;
                    r.done     = 1'b1;
                end else if (r.st.value_stage == VS_NAME) begin
                    r.st.err = ERR_NO_COLON;
                end
            end
            default: begin
            end
        endcase
        r.st = line_restart(r.st);
        return r;
    endfunction

    function automatic t_res parse_step(input t_parse s_in, input logic [7:0] c);
        t_res          r;
        logic [LB-1:0] rem;
        r      = '0;
        r.st   = s_in;
        r.kind = KIND_NONE;
        r.done = 1'b0;
        rem    = s_in.body_rem - {{(LB-1){1'b0}}, 1'b1};
        if (s_in.err != ERR_NONE || s_in.phase == PH_DONE) begin
            r.kind = KIND_NONE;
        end else if (s_in.phase == PH_BODY || s_in.phase == PH_CDATA) begin
            r.kind        = KIND_BODY;
            r.st.body_rem = rem;
            if (rem == '0) begin
                if (s_in.phase == PH_BODY) begin
                    r.st.phase = PH_DONE;
                    r.done     = 1'b1;
                end else begin
                    r.st.phase = PH_CTERM;
                end
            end
        end else begin
            case (s_in.phase)
                PH_HEAD:  r.kind = KIND_HEADER;
                PH_CSIZE: r.kind = KIND_CSIZE;
                PH_CTERM: r.kind = KIND_CTERM;
                PH_TRAIL: r.kind = KIND_TRAIL;
                default:  r.kind = KIND_START;
            endcase
            if (s_in.cr_pending && c == CH_LF) begin
                r.st.cr_pending = 1'b0;
                r               = line_end(r.st);
                r.kind          = KIND_LF;
            end else begin
                if (r.st.cr_pending) begin
                    r.st.cr_pending = 1'b0;
                    r.st            = line_char(r.st, CH_CR);
                end
                if (c == CH_CR) begin
                    r.st.cr_pending = 1'b1;
                end else begin
                    r.st = line_char(r.st, c);
                end
            end
        end
        return r;
    endfunction

    t_parse     r_st;
    t_parse     n_st;
    t_res       n_res;
    logic       r_out_valid;
    logic [7:0] r_byte_out;
    logic [2:0] r_byte_kind;
    logic       r_msg_done;
    logic [2:0] r_err;
    logic       in_xfer;

    assign o_ready = !r_out_valid || i_ready;
    assign in_xfer = i_valid && o_ready;

    always_comb begin
        n_res = parse_step(i_new_message ? parse_reset() : r_st, i_data_byte);
        n_st  = in_xfer ? n_res.st : r_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= parse_reset();
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_out_valid <= in_xfer || (r_out_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_byte_out  <= i_data_byte;
            r_byte_kind <= n_res.kind;
            r_msg_done  <= n_res.done;
            r_err       <= n_res.st.err;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_byte_out     = r_byte_out;
    assign o_byte_kind    = r_byte_kind;
    assign o_message_done = r_msg_done;
    assign o_error_code   = r_err;

`ifndef SYNTHESIS
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.err != ERR_NONE && !(in_xfer && i_new_message)) |=> r_st.err == $past(r_st.err))
        else $error("error code changed without a new message");

    a_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_message_done) |-> (o_byte_kind == KIND_BODY || o_byte_kind == KIND_LF))
        else $error("completion on a byte that is neither body nor line end");

    a_done_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_message_done) |-> o_error_code == ERR_NONE)
        else $error("completion reported together with an error");

    a_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.phase == PH_DONE |-> r_st.err == ERR_NONE)
        else $error("completed message carries an error");
`endif

endmodule
